/* design/i2a_pkg.sv */
package i2a_pkg;

  // command codes carried in the input tuser
  localparam logic [2:0] CmdSignedDec   = 3'd0;
  localparam logic [2:0] CmdUnsignedDec = 3'd1;
  localparam logic [2:0] CmdHexLower    = 3'd2;
  localparam logic [2:0] CmdHexUpper    = 3'd3;
  localparam logic [2:0] CmdPointer     = 3'd4;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h78;

  localparam int unsigned CountWidth = 31;

  typedef logic [CountWidth-1:0] count_t;

  // one digit to its ascii character, lower or upper case letters
  function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [7:0] ch;
    if (digit < 4'd10) begin
      ch = ChZero + {4'd0, digit};
    end else if (upper) begin
      ch = 8'h41 + {4'd0, digit - 4'd10};
    end else begin
      ch = 8'h61 + {4'd0, digit - 4'd10};
    end
    return ch;
  endfunction

endpackage

/* design/i2a_div_unit.sv */
module i2a_div_unit #(
  parameter int unsigned W = 64
) (
  input  logic [W-1:0] val_i,
  input  logic         hex_i,
  output logic [W-1:0] quot_o,
  output logic [3:0]   rem_o
);

  logic [31:0] v32;
  logic [63:0] prod;
  logic [28:0] q10;
  logic [31:0] q_times_ten;
  logic [31:0] dec_rem;

  assign v32 = val_i[31:0];

  // divide by ten as a multiply by the rounded reciprocal 2^35/10
  assign prod        = {32'd0, v32} * 64'h0000_0000_CCCC_CCCD;
  assign q10         = prod[63:35];
  assign q_times_ten = {q10, 3'd0} + {2'd0, q10, 1'b0};
  assign dec_rem     = v32 - q_times_ten;

  always_comb begin
    if (hex_i) begin
      quot_o = val_i >> 4;
      rem_o  = val_i[3:0];
    end else begin
      quot_o = {{(W-29){1'b0}}, q10};
      rem_o  = dec_rem[3:0];
    end
  end

endmodule

/* design/integer_to_ascii_radix_formatter.sv */
// Formats one number per input transaction as ASCII, most significant character first,
// leading zeros suppressed (zero prints "0"). tuser selects signed decimal, unsigned
// decimal, lower or upper hex of the low 32 bits, or "0x" plus lower hex of the low
// VALUE_WIDTH bits; other codes are accepted and print nothing. One divide unit
// (divide by ten through a reciprocal multiply, or a 4-bit shift for hex) yields one
// digit per cycle, then one character per cycle leaves through the output register
// while the output is not stalled. An item is accepted, then divided down to its digits
// (up to 10 decimal or (VALUE_WIDTH+3)/4 hex), then sent out sign or prefix first.
// The input is not ready while an item is in work. Every character carries tlast on
// the final one and the running character count, which saturates at 2^31-1.
module integer_to_ascii_radix_formatter #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] char_out, [38:8] total_printed, [39] zero
  output logic        m_axis_tlast
);

  localparam int unsigned HexDigits = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned MaxDigits = (HexDigits > 10) ? HexDigits : 10;
  localparam int unsigned IdxWidth  = $clog2(MaxDigits);
  localparam int unsigned NdWidth   = $clog2(MaxDigits + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   hex_q, hex_d;
  logic                   upper_q, upper_d;
  logic                   neg_q, neg_d;
  logic [1:0]             pfx_q, pfx_d;
  logic [NdWidth-1:0]     nd_q, nd_d;
  logic [3:0]             digit_q [MaxDigits];
  i2a_pkg::count_t        count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] quot;
  logic [3:0]             rem;
  logic                   in_xfer;
  logic                   out_free;
  logic                   dig_we;
  logic [NdWidth-1:0]     rd_nd;
  logic [IdxWidth-1:0]    rd_idx;
  logic [31:0]            mag32;

  i2a_div_unit #(
    .W(VALUE_WIDTH)
  ) u_div (
    .val_i (val_q),
    .hex_i (hex_q),
    .quot_o(quot),
    .rem_o (rem)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign rd_nd         = nd_q - NdWidth'(1);
  assign rd_idx        = rd_nd[IdxWidth-1:0];
  assign mag32         = s_axis_tdata[31] ? (~s_axis_tdata[31:0] + 32'd1) : s_axis_tdata[31:0];

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    hex_d       = hex_q;
    upper_d     = upper_q;
    neg_d       = neg_q;
    pfx_d       = pfx_q;
    nd_d        = nd_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    dig_we      = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          nd_d    = '0;
          neg_d   = 1'b0;
          pfx_d   = 2'd0;
          upper_d = 1'b0;
          hex_d   = 1'b1;
          val_d   = {{(VALUE_WIDTH-32){1'b0}}, s_axis_tdata[31:0]};
          state_d = StDiv;
          case (s_axis_tuser)
            i2a_pkg::CmdSignedDec: begin
              hex_d = 1'b0;
              neg_d = s_axis_tdata[31];
              val_d = {{(VALUE_WIDTH-32){1'b0}}, mag32};
            end
            i2a_pkg::CmdUnsignedDec: begin
              hex_d = 1'b0;
            end
            i2a_pkg::CmdHexLower: begin
            end
            i2a_pkg::CmdHexUpper: begin
              upper_d = 1'b1;
            end
            i2a_pkg::CmdPointer: begin
              pfx_d = 2'd2;
              val_d = s_axis_tdata[VALUE_WIDTH-1:0];
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StDiv: begin
        dig_we = 1'b1;
        val_d  = quot;
        nd_d   = nd_q + NdWidth'(1);
        if (quot == '0) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          if (count_q != '1) begin
            count_d = count_q + i2a_pkg::count_t'(1);
          end
          if (neg_q) begin
            out_char_d = i2a_pkg::ChMinus;
            neg_d      = 1'b0;
          end else if (pfx_q == 2'd2) begin
            out_char_d = i2a_pkg::ChZero;
            pfx_d      = 2'd1;
          end else if (pfx_q == 2'd1) begin
            out_char_d = i2a_pkg::ChX;
            pfx_d      = 2'd0;
          end else begin
            out_char_d = i2a_pkg::digit_char(digit_q[rd_idx], upper_q);
            nd_d       = rd_nd;
            if (nd_q == NdWidth'(1)) begin
              out_last_d = 1'b1;
              state_d    = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      nd_q        <= '0;
      neg_q       <= 1'b0;
      pfx_q       <= 2'd0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      nd_q        <= nd_d;
      neg_q       <= neg_d;
      pfx_q       <= pfx_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    hex_q      <= hex_d;
    upper_q    <= upper_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (dig_we) begin
      digit_q[nd_q[IdxWidth-1:0]] <= rem;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, count_q, out_char_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* tb/integer_to_ascii_radix_formatter_test.sv */
`timescale 1ns / 1ps

module integer_to_ascii_radix_formatter_test;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam i2a_pkg::count_t CountMax = '1;

  typedef struct packed {
    logic [7:0]      ch;
    logic            last;
    i2a_pkg::count_t total;
  } glyph_t;

  // works out the characters of every accepted number and holds them until they leave
  class glyph_scoreboard;
    glyph_t          pending_glyphs[$];
    i2a_pkg::count_t printed_total;
    bit              failed;

    function new();
      printed_total = '0;
      failed = 1'b0;
    endfunction

    function void push_glyph(logic [7:0] ch, logic last);
      glyph_t g;
      if (printed_total != CountMax) printed_total = printed_total + 1'b1;
      g.ch = ch;
      g.last = last;
      g.total = printed_total;
      pending_glyphs.push_back(g);
    endfunction

    function void note_number(logic [2:0] cmd, logic [63:0] value);
      logic [63:0] mag;
      logic [3:0]  digits[20];
      int unsigned radix;
      int          nd;
      bit          neg;
      bit          prefix;
      string       alphabet;
      neg = 1'b0;
      prefix = 1'b0;
      radix = 16;
      alphabet = "0123456789abcdef";
      mag = {32'd0, value[31:0]};
      case (cmd)
        i2a_pkg::CmdSignedDec: begin
          radix = 10;
          if (value[31]) begin
            neg = 1'b1;
            mag = {32'd0, -value[31:0]};
          end
        end
        i2a_pkg::CmdUnsignedDec: radix = 10;
        i2a_pkg::CmdHexLower: ;
        i2a_pkg::CmdHexUpper: alphabet = "0123456789ABCDEF";
        i2a_pkg::CmdPointer: begin
          prefix = 1'b1;
          mag = value;
          if (ValueWidth < 64) mag = value & ((64'd1 << ValueWidth) - 64'd1);
        end
        default: return; // undefined modes print nothing
      endcase
      nd = 0;
      do begin
        digits[nd] = 4'(mag % radix);
        mag = mag / radix;
        nd++;
      end while (mag != 0 && nd < 20);
      if (neg) push_glyph(i2a_pkg::ChMinus, 1'b0);
      if (prefix) begin
        push_glyph(i2a_pkg::ChZero, 1'b0);
        push_glyph(i2a_pkg::ChX, 1'b0);
      end
      for (int i = nd - 1; i >= 0; i--) push_glyph(alphabet[digits[i]], i == 0);
    endfunction

    function void check_glyph(logic [7:0] ch, logic last, i2a_pkg::count_t total);
      glyph_t want;
      if (pending_glyphs.size() == 0) begin
        $display("%0t: unexpected character %h last %b total %0d", $time, ch, last, total);
        failed = 1'b1;
        return;
      end
      want = pending_glyphs.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: char expected %h actual %h", $time, want.ch, ch);
        failed = 1'b1;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        failed = 1'b1;
      end
      if (total !== want.total) begin
        $display("%0t: total expected %0d actual %0d", $time, want.total, total);
        failed = 1'b1;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] value
  logic [2:0]  s_axis_tuser = '0;   // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [7:0] char_out, [38:8] total_printed, [39] zero
  logic        m_axis_tlast;

  glyph_scoreboard sb = new();
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold = 0;
  int unsigned cycle_count = 0;

  integer_to_ascii_radix_formatter #(
    .VALUE_WIDTH(ValueWidth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sampled straight after the edge, so both sides show their pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_number(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_glyph(m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[38:8]);
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_number(input logic [2:0] cmd, input logic [63:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= {$urandom, $urandom};
      s_axis_tuser <= 3'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tuser <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending_glyphs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] p;
    p = 64'd1;
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(20));
      2: return {$urandom, $urandom} >> $urandom_range(63);
      3: begin
        // around a power of ten, where the digit count changes
        repeat ($urandom_range(19)) p = p * 10;
        return $urandom_range(1) ? p + $urandom_range(2) : p - $urandom_range(2);
      end
      4: return {$urandom, $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                             : 32'hFFFF_FFFF - $urandom_range(3)};
      default: return {$urandom, $urandom} | 64'hF000_0000_F000_0000;
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [2:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_number(cmd, random_value());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every mode, most negative, ignored upper bits
    send_number(i2a_pkg::CmdSignedDec, 64'd0);
    send_number(i2a_pkg::CmdSignedDec, 64'd1);
    send_number(i2a_pkg::CmdSignedDec, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CmdSignedDec, 64'h0000_0000_8000_0000);
    send_number(i2a_pkg::CmdSignedDec, 64'h0000_0000_7FFF_FFFF);
    send_number(i2a_pkg::CmdSignedDec, 64'hFFFF_FFFF_0000_0005);
    send_number(i2a_pkg::CmdUnsignedDec, 64'd0);
    send_number(i2a_pkg::CmdUnsignedDec, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CmdUnsignedDec, 64'd1_000_000_000);
    send_number(i2a_pkg::CmdHexLower, 64'd0);
    send_number(i2a_pkg::CmdHexLower, 64'h1234_5678_DEAD_BEEF);
    send_number(i2a_pkg::CmdHexLower, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CmdHexUpper, 64'h0000_0000_ABCD_EF01);
    send_number(i2a_pkg::CmdHexUpper, 64'hFFFF_FFFF_0000_000F);
    send_number(i2a_pkg::CmdPointer, 64'd0);
    send_number(i2a_pkg::CmdPointer, 64'd1);
    send_number(i2a_pkg::CmdPointer, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CmdPointer, 64'h0123_4567_89AB_CDEF);
    send_number(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(3'd6, 64'd0);
    send_number(3'd7, 64'h8000_0000_0000_0000);
    send_number(i2a_pkg::CmdHexUpper, 64'd10);

    // no idling at all, with a long receiver hold-off to back the block up
    sink_hold = 300;
    send_random(52);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    src_idle_pct = 69;
    send_random(52);

    src_idle_pct = 0;
    sink_stall_pct = 69;
    send_random(52);

    src_idle_pct = 17;
    sink_stall_pct = 17;
    send_random(52);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (!sb.failed && sb.pending_glyphs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
